### sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared types, codes and sizes of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [2:0] F_INS_HEAD = 3'd0;
    localparam logic [2:0] F_INS_TAIL = 3'd1;
    localparam logic [2:0] F_INS_POS  = 3'd2;
    localparam logic [2:0] F_DEL_HEAD = 3'd3;
    localparam logic [2:0] F_DEL_TAIL = 3'd4;
    localparam logic [2:0] F_DEL_POS  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_STEP = 9'b000000010,
        S_SRD  = 9'b000000100,
        S_SWR  = 9'b000001000,
        S_PUT  = 9'b000010000,
        S_HRD  = 9'b000100000,
        S_TRD  = 9'b001000000,
        S_TCAP = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

endpackage

### sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list of signed 32-bit values with 1-based positions
// ----------------------------------------------------------------------------
// usage
//   input channel i_valid/o_ready carries one edit item: i_func, i_value,
//   i_position. output channel o_valid/i_ready returns one result item per
//   edit: o_status, o_count, o_head_value, o_tail_value.
//   entries live in a single-port-style memory; a small sequencer moves one
//   entry at a time in three steps (check, read, write) through that one port.
//   the next item can be taken in the cycle after the result is loaded; an
//   edit moves at most CAPACITY-1 entries.
//   the result sits in an output register, so a new item is accepted while
//   the previous result still waits; if the receiver stalls, the sequencer
//   holds its finished result until the output register frees up.
//   reset (synchronous, active low) empties the list and drops any pending
//   result; memory contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module positional_list_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_func,
    input  logic signed [31:0]    i_value,
    input  logic [ple_pkg::POS_W-1:0] i_position,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic [4:0]            o_count,
    output logic signed [31:0]    o_head_value,
    output logic signed [31:0]    o_tail_value
);
    import ple_pkg::*;

    logic [31:0]      r_mem [CAPACITY];
    logic [31:0]      r_rdata;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_p, n_p;
    logic             r_ins, n_ins;
    logic [1:0]       r_st, n_st;
    logic             r_o_valid, n_o_valid;
    logic [31:0]      r_val;
    logic [31:0]      r_head;
    logic [31:0]      r_tail;
    logic [1:0]       r_o_status;
    logic [4:0]       r_o_count;
    logic [31:0]      r_o_head;
    logic [31:0]      r_o_tail;

    logic             accept;
    logic             load_out;
    logic             d_ins;
    logic [1:0]       d_st;
    logic [CNT_W-1:0] d_p;
    logic [CNT_W-1:0] pos_m1;
    logic             full;
    logic             empty;
    logic             ins_bad;
    logic             del_bad;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [31:0]      mem_wd;
    logic [IDX_W-1:0] mem_ra;

    assign accept   = i_valid && o_ready;
    assign load_out = (r_state == S_FIN) && (!r_o_valid || i_ready);

    // edit decode
    always_comb begin
        full    = (r_cnt == CNT_W'(CAPACITY));
        empty   = (r_cnt == '0);
        pos_m1  = CNT_W'(i_position) - CNT_W'(1);
        ins_bad = (i_position == '0) ||
                  (CMP_W'(i_position) > (CMP_W'(r_cnt) + CMP_W'(1)));
        del_bad = (i_position == '0) || (CMP_W'(i_position) > CMP_W'(r_cnt));
        d_ins   = 1'b0;
        d_p     = '0;
        d_st    = ST_OK;
        case (i_func)
            F_INS_HEAD: begin
                d_ins = 1'b1;
                d_p   = '0;
                d_st  = full ? ST_FULL : ST_OK;
            end
            F_INS_TAIL: begin
                d_ins = 1'b1;
                d_p   = r_cnt;
                d_st  = full ? ST_FULL : ST_OK;
            end
            F_INS_POS: begin
                d_ins = 1'b1;
                d_p   = pos_m1;
                d_st  = ins_bad ? ST_BADPOS : (full ? ST_FULL : ST_OK);
            end
            F_DEL_HEAD: begin
                d_p  = '0;
                d_st = empty ? ST_EMPTY : ST_OK;
            end
            F_DEL_TAIL: begin
                d_p  = r_cnt - CNT_W'(1);
                d_st = empty ? ST_EMPTY : ST_OK;
            end
            F_DEL_POS: begin
                d_p  = pos_m1;
                d_st = empty ? ST_EMPTY : (del_bad ? ST_BADPOS : ST_OK);
            end
            default: begin
                d_st = ST_BADPOS;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_p       = r_p;
        n_ins     = r_ins;
        n_st      = r_st;
        n_o_valid = r_o_valid;
        mem_we    = 1'b0;
        mem_wa    = r_idx[IDX_W-1:0];
        mem_wd    = r_rdata;
        mem_ra    = '0;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ins = d_ins;
                    n_p   = d_p;
                    n_st  = d_st;
                    n_idx = d_ins ? r_cnt : d_p;
                    n_state = (d_st == ST_OK) ? S_STEP : S_HRD;
                end
            end
            S_STEP: begin
                if (r_ins) begin
                    n_state = (r_idx > r_p) ? S_SRD : S_PUT;
                end else if ((r_idx + CNT_W'(1)) < r_cnt) begin
                    n_state = S_SRD;
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_HRD;
                end
            end
            S_SRD: begin
                mem_ra  = r_ins ? IDX_W'(r_idx - CNT_W'(1)) : IDX_W'(r_idx + CNT_W'(1));
                n_state = S_SWR;
            end
            S_SWR: begin
                mem_we  = 1'b1;
                n_idx   = r_ins ? (r_idx - CNT_W'(1)) : (r_idx + CNT_W'(1));
                n_state = S_STEP;
            end
            S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_p[IDX_W-1:0];
                mem_wd  = r_val;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_HRD;
            end
            S_HRD: begin
                mem_ra  = '0;
                n_state = S_TRD;
            end
            S_TRD: begin
                mem_ra  = IDX_W'(r_cnt - CNT_W'(1));
                n_state = S_TCAP;
            end
            S_TCAP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (load_out) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_p       <= '0;
            r_ins     <= 1'b0;
            r_st      <= ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
            r_p       <= n_p;
            r_ins     <= n_ins;
            r_st      <= n_st;
            r_o_valid <= n_o_valid;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= i_value;
        end
        if (r_state == S_TRD) begin
            r_head <= r_rdata;
        end
        if (r_state == S_TCAP) begin
            r_tail <= r_rdata;
        end
        if (load_out) begin
            r_o_status <= r_st;
            r_o_count  <= 5'(r_cnt);
            r_o_head   <= (r_cnt == '0) ? 32'd0 : r_head;
            r_o_tail   <= (r_cnt == '0) ? 32'd0 : r_tail;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_count      = r_o_count;
    assign o_head_value = r_o_head;
    assign o_tail_value = r_o_tail;

endmodule

### sv/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// port-level checks of the positional list engine
// ----------------------------------------------------------------------------
module ple_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [1:0]            o_status,
    input logic [4:0]            o_count,
    input logic signed [31:0]    o_head_value,
    input logic signed [31:0]    o_tail_value
);
    import ple_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_count) &&
            $stable(o_head_value) && $stable(o_tail_value))
        else $error("result changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_count == 5'd0) |-> (o_head_value == 0) && (o_tail_value == 0))
        else $error("empty list with nonzero head or tail");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_count == 5'(CAPACITY)))
        else $error("full status without full count");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_count == 5'd0))
        else $error("empty status with nonzero count");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_count      (o_count),
    .o_head_value (o_head_value),
    .o_tail_value (o_tail_value)
);

### tb/sv/positional_list_engine_test.sv
// ----------------------------------------------------------------------------
// positional_list_engine_test
// checks every list edit, its status and the head, tail and count it returns
// ----------------------------------------------------------------------------
// a shadow list is edited the same way as the engine for each accepted item,
// and the result it predicts waits in a queue until the engine's result item
// arrives. directed tests cover an empty list, a full list and every failing
// edit. a long receiver hold-off backs the engine up. random edits then let
// the list wander between empty and full, first with random idling on both
// channels and at the end as a steady stream.
// ----------------------------------------------------------------------------
module positional_list_engine_test;

    import ple_pkg::*;

    localparam logic [2:0] F_UNUSED_6 = 3'd6;
    localparam logic [2:0] F_UNUSED_7 = 3'd7;
    localparam int         TAIL_WAIT  = 3 * CAPACITY + 12;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         count;
        logic signed [31:0] head;
        logic signed [31:0] tail;
    } t_list_result;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic [2:0]               i_func       = F_INS_HEAD;
    logic signed [31:0]       i_value      = '0;
    logic [POS_W-1:0]         i_position   = '0;
    logic                     i_ready      = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic [4:0]               o_count;
    logic signed [31:0]       o_head_value;
    logic signed [31:0]       o_tail_value;

    logic signed [31:0]       shadow_list[$];
    t_list_result             pending_results[$];

    bit sender_idle_en   = 1'b1;
    bit receiver_idle_en = 1'b1;
    int hold_request     = 0;
    int stall_left       = 0;
    int error_count      = 0;
    int edits_sent       = 0;
    int results_checked  = 0;
    int full_hits        = 0;
    int empty_hits       = 0;
    int badpos_hits      = 0;
    int longest_hold     = 0;

    positional_list_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_head_value (o_head_value),
        .o_tail_value (o_tail_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_list_result apply_list_edit(input logic [2:0] f,
                                                     input logic signed [31:0] v,
                                                     input logic [POS_W-1:0] p);
        t_list_result res;
        int n;
        n = shadow_list.size();
        res.status = ST_OK;
        case (f)
            F_INS_HEAD: begin
                if (n >= CAPACITY) res.status = ST_FULL;
                else shadow_list.push_front(v);
            end
            F_INS_TAIL: begin
                if (n >= CAPACITY) res.status = ST_FULL;
                else shadow_list.push_back(v);
            end
            F_INS_POS: begin
                if (p == 0 || int'(p) > n + 1) res.status = ST_BADPOS;
                else if (n >= CAPACITY) res.status = ST_FULL;
                else shadow_list.insert(int'(p) - 1, v);
            end
            F_DEL_HEAD: begin
                if (n == 0) res.status = ST_EMPTY;
                else void'(shadow_list.pop_front());
            end
            F_DEL_TAIL: begin
                if (n == 0) res.status = ST_EMPTY;
                else void'(shadow_list.pop_back());
            end
            F_DEL_POS: begin
                if (n == 0) res.status = ST_EMPTY;
                else if (p == 0 || int'(p) > n) res.status = ST_BADPOS;
                else shadow_list.delete(int'(p) - 1);
            end
            default: res.status = ST_BADPOS;
        endcase
        case (res.status)
            ST_FULL:   full_hits++;
            ST_EMPTY:  empty_hits++;
            ST_BADPOS: badpos_hits++;
            default:   ;
        endcase
        n = shadow_list.size();
        res.count = n[4:0];
        res.head  = (n > 0) ? shadow_list[0] : '0;
        res.tail  = (n > 0) ? shadow_list[n - 1] : '0;
        return res;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_edit(input logic [2:0] f, input logic signed [31:0] v,
                             input logic [POS_W-1:0] p);
        @(negedge i_clk);
        if (sender_idle_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= f;
        i_value    <= v;
        i_position <= p;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_results.push_back(apply_list_edit(f, v, p));
        edits_sent++;
    endtask

    // receiver side: random stall bursts, or one long counted hold-off
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            stall_left = hold_request;
            if (hold_request > longest_hold) longest_hold = hold_request;
            hold_request = 0;
        end else if (stall_left == 0 && receiver_idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result item with none expected: status %0d count %0d",
                                          o_status, o_count));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", o_status,
                                              want.status));
                if (o_count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d", o_count, want.count));
                if (o_head_value !== want.head)
                    report_mismatch($sformatf("head %h, expected %h", o_head_value,
                                              want.head));
                if (o_tail_value !== want.tail)
                    report_mismatch($sformatf("tail %h, expected %h", o_tail_value,
                                              want.tail));
            end
        end
    end

    task automatic test_empty_list();
        send_edit(F_DEL_HEAD, pick_value(), 5'd1);
        send_edit(F_DEL_TAIL, pick_value(), 5'd1);
        send_edit(F_DEL_POS, pick_value(), 5'd0);
        send_edit(F_INS_POS, 32'sd5, 5'd0);
        send_edit(F_INS_POS, 32'sd6, 5'd2);
        send_edit(F_UNUSED_6, 32'sd7, 5'd1);
        send_edit(F_UNUSED_7, 32'sd8, 5'd31);
        send_edit(F_INS_POS, 32'sh8000_0000, 5'd1);
        send_edit(F_INS_HEAD, 32'sh7fff_ffff, 5'd0);
        send_edit(F_INS_TAIL, -32'sd1, 5'd31);
        send_edit(F_INS_POS, '0, 5'd2);
        send_edit(F_DEL_POS, '0, 5'd5);
        send_edit(F_DEL_POS, '0, 5'd4);
        send_edit(F_DEL_POS, '0, 5'd2);
        send_edit(F_DEL_TAIL, '0, 5'd0);
        send_edit(F_DEL_HEAD, '0, 5'd0);
    endtask

    task automatic test_full_list();
        int n;
        while (shadow_list.size() < CAPACITY) begin
            n = shadow_list.size();
            case ($urandom_range(0, 2))
                0:       send_edit(F_INS_HEAD, pick_value(), POS_W'($urandom_range(0, 31)));
                1:       send_edit(F_INS_TAIL, pick_value(), POS_W'($urandom_range(0, 31)));
                default: send_edit(F_INS_POS, pick_value(), POS_W'($urandom_range(1, n + 1)));
            endcase
        end
        send_edit(F_INS_HEAD, pick_value(), 5'd1);
        send_edit(F_INS_TAIL, pick_value(), 5'd1);
        send_edit(F_INS_POS, pick_value(), 5'd0);
        send_edit(F_INS_POS, pick_value(), 5'd31);
        send_edit(F_INS_POS, pick_value(), POS_W'(CAPACITY + 1));
        send_edit(F_INS_POS, pick_value(), 5'd1);
        send_edit(F_DEL_POS, '0, POS_W'(CAPACITY + 1));
        send_edit(F_DEL_POS, '0, POS_W'(CAPACITY));
        while (shadow_list.size() > 0) begin
            n = shadow_list.size();
            case ($urandom_range(0, 2))
                0:       send_edit(F_DEL_HEAD, pick_value(), POS_W'($urandom_range(0, 31)));
                1:       send_edit(F_DEL_TAIL, pick_value(), POS_W'($urandom_range(0, 31)));
                default: send_edit(F_DEL_POS, pick_value(), POS_W'($urandom_range(1, n)));
            endcase
        end
        send_edit(F_DEL_POS, '0, 5'd31);
    endtask

    task automatic test_backpressure();
        sender_idle_en = 1'b0;
        hold_request   = 200;
        repeat (12) send_edit(F_INS_TAIL, pick_value(), POS_W'($urandom_range(0, 31)));
        sender_idle_en = 1'b1;
    endtask

    task automatic test_random_edits(input int items, input int insert_pct);
        logic [2:0]       f;
        logic [POS_W-1:0] p;
        int               n;
        repeat (items) begin
            n = shadow_list.size();
            if ($urandom_range(0, 99) < 4) begin
                f = $urandom_range(0, 1) ? F_UNUSED_6 : F_UNUSED_7;
                p = POS_W'($urandom_range(0, 31));
            end else if ($urandom_range(0, 99) < insert_pct) begin
                case ($urandom_range(0, 2))
                    0:       f = F_INS_HEAD;
                    1:       f = F_INS_TAIL;
                    default: f = F_INS_POS;
                endcase
                p = ($urandom_range(0, 9) < 8) ? POS_W'($urandom_range(1, n + 1))
                                               : POS_W'($urandom_range(0, 31));
            end else begin
                case ($urandom_range(0, 2))
                    0:       f = F_DEL_HEAD;
                    1:       f = F_DEL_TAIL;
                    default: f = F_DEL_POS;
                endcase
                p = (n > 0 && $urandom_range(0, 9) < 8) ? POS_W'($urandom_range(1, n))
                                                        : POS_W'($urandom_range(0, 31));
            end
            send_edit(f, pick_value(), p);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_full_list();
        test_backpressure();
        test_random_edits(350, 50);
        test_random_edits(250, 80);
        test_random_edits(250, 20);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        test_random_edits(300, 50);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("ran %0d edits and checked %0d results; %0d full, %0d empty, %0d bad position",
                 edits_sent, results_checked, full_hits, empty_hits, badpos_hits);
        $display("longest receiver hold-off %0d cycles, %0d mismatches", longest_hold,
                 error_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout: list engine stopped making progress");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
